FILE: src/stps_pkg.sv
// ----------------------------------------------------------------------------
// stps_pkg
// Shared constants and types for the sorted table predecessor search unit.
// ----------------------------------------------------------------------------
package stps_pkg;

  localparam int ENTRY_INDEX_WIDTH = 10;
  localparam int POS_PORT_WIDTH    = 32;
  localparam int ANCHOR_WIDTH      = 10;
  localparam int COUNT_WIDTH       = 11;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                    done;
    logic [ANCHOR_WIDTH-1:0] anchor_index;
  } stps_result_t;

endpackage

FILE: src/stps_table.sv
// ----------------------------------------------------------------------------
// stps_table
// Start table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stps_table #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/stps_search.sv
// ----------------------------------------------------------------------------
// stps_search
// Binary search sequencer: one table read and one compare per probe.
// ----------------------------------------------------------------------------
module stps_search
  import stps_pkg::*;
#(
  parameter int TABLE_DEPTH    = 1024,
  parameter int POSITION_WIDTH = 32,
  parameter int AW             = 10,
  parameter int CW             = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      query_start,
  input  logic [POSITION_WIDTH-1:0] query_pos,
  input  logic [COUNT_WIDTH-1:0]    entries_in_use,
  output logic                      busy,
  output stps_result_t              result,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  logic [POSITION_WIDTH-1:0] rd_data
);

  localparam int NW = (CW > COUNT_WIDTH) ? CW : COUNT_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP
  } state_t;

  state_t                    state;
  logic [CW-1:0]             lo;
  logic [CW-1:0]             hi;
  logic [AW-1:0]             mid;
  logic [POSITION_WIDTH-1:0] pos;
  logic [CW-1:0]             count;
  logic [CW-1:0]             mid_calc;
  logic [NW-1:0]             entries_ext;

  assign entries_ext = NW'(entries_in_use);

  always_comb begin
    if (entries_ext == '0) begin
      count = CW'(1);
    end else if (entries_ext > NW'(TABLE_DEPTH)) begin
      count = CW'(TABLE_DEPTH);
    end else begin
      count = CW'(entries_ext);
    end
  end

  assign mid_calc = lo + ((hi - lo) >> 1);
  assign busy     = (state != S_IDLE);
  assign rd_en    = (state == S_PROBE) && (lo < hi);
  assign rd_addr  = AW'(mid_calc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      result.done <= 1'b0;
    end else begin
      result.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (query_start) begin
            pos   <= query_pos;
            lo    <= '0;
            hi    <= count;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid   <= AW'(mid_calc);
            state <= S_CMP;
          end else begin
            result.done         <= 1'b1;
            result.anchor_index <= (lo == '0) ? '0 : ANCHOR_WIDTH'(lo - CW'(1));
            state               <= S_IDLE;
          end
        end
        S_CMP: begin
          if (rd_data <= pos) begin
            lo <= CW'(mid) + CW'(1);
          end else begin
            hi <= CW'(mid);
          end
          state <= S_PROBE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/sorted_table_predecessor_search_unit.sv
// A query makes P probes, at most ceil(log2(N+1)) for N searched entries.
// Each probe is one table read followed by one compare.
// Writes never raise busy; a query holds busy from accept until done, and no
// new request is accepted while busy is high.
// Reset (rst, synchronous) clears the sequencer and sets entries_in_use to 1;
// table contents are undefined until written. Results cannot be stalled.
// ----------------------------------------------------------------------------
// sorted_table_predecessor_search_unit
// Predecessor search over a loaded ascending table of start positions.
// ----------------------------------------------------------------------------
module sorted_table_predecessor_search_unit
  import stps_pkg::*;
#(
  parameter int TABLE_DEPTH    = 1024,
  parameter int POSITION_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd,
  input  logic [ENTRY_INDEX_WIDTH-1:0] entry_index,
  input  logic [POS_PORT_WIDTH-1:0]    position,
  output logic                         done,
  output logic [ANCHOR_WIDTH-1:0]      anchor_index,
  input  logic                         cfg_wr_en,
  input  logic [COUNT_WIDTH-1:0]       cfg_wr_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [COUNT_WIDTH-1:0]    entries_in_use;
  logic [POSITION_WIDTH-1:0] pos_w;
  logic                      accept;
  logic                      wr_en;
  logic                      query_start;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [POSITION_WIDTH-1:0] rd_data;
  stps_result_t              result;

  assign pos_w       = POSITION_WIDTH'(position);
  assign accept      = start && !busy;
  assign wr_en       = accept && (cmd == CMD_WRITE) && (32'(entry_index) < TABLE_DEPTH);
  assign query_start = accept && (cmd == CMD_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= COUNT_WIDTH'(1);
    end else if (cfg_wr_en) begin
      entries_in_use <= cfg_wr_data;
    end
  end

  stps_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (POSITION_WIDTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(entry_index)),
    .wr_data (pos_w),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stps_search #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .POSITION_WIDTH (POSITION_WIDTH),
    .AW             (AW),
    .CW             (CW)
  ) u_search (
    .clk            (clk),
    .rst            (rst),
    .query_start    (query_start),
    .query_pos      (pos_w),
    .entries_in_use (entries_in_use),
    .busy           (busy),
    .result         (result),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  assign done         = result.done;
  assign anchor_index = result.anchor_index;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a search in progress");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    query_start |=> busy)
    else $error("query accepted but sequencer not busy");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("table read and write in the same cycle");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_WRITE)) |=> !done && !busy)
    else $error("write request produced activity");
`endif

endmodule

FILE: bench/sorted_table_predecessor_search_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_table_predecessor_search_unit_tb
// Loads ascending start tables of many sizes, with occasional out-of-order
// writes, and runs predecessor queries against them. A scoreboard mirrors
// the table and the entry count and checks every anchor index in order.
// ----------------------------------------------------------------------------
module sorted_table_predecessor_search_unit_tb;
  import stps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SIZE  = 1024;
  localparam int ITEM_TARGET = 1800;
  localparam int DRAIN_WAIT  = 25;
  localparam int STALL_LIMIT = 4000;

  class anchor_scoreboard;
    logic [POS_PORT_WIDTH-1:0] starts [TABLE_SIZE];
    logic [COUNT_WIDTH-1:0]    entry_count;
    logic [ANCHOR_WIDTH-1:0]   anchors_due [$];
    int mismatches;
    int writes_seen;
    int queries_seen;
    int results_seen;

    function new();
      entry_count = 1;
      foreach (starts[i]) starts[i] = '0;
      mismatches = 0;
      writes_seen = 0;
      queries_seen = 0;
      results_seen = 0;
    endfunction

    function void set_count(logic [COUNT_WIDTH-1:0] value);
      entry_count = value;
    endfunction

    function logic [ANCHOR_WIDTH-1:0] find_anchor(logic [POS_PORT_WIDTH-1:0] pos);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = (entry_count == 0) ? 1 : ((entry_count > TABLE_SIZE) ? TABLE_SIZE : entry_count);
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (starts[mid] <= pos) lo = mid + 1;
        else hi = mid;
      end
      return (lo == 0) ? '0 : ANCHOR_WIDTH'(lo - 1);
    endfunction

    function void note_request(logic op, logic [ENTRY_INDEX_WIDTH-1:0] slot,
                               logic [POS_PORT_WIDTH-1:0] pos);
      if (op == CMD_WRITE) begin
        starts[slot] = pos;
        writes_seen++;
      end else begin
        anchors_due.push_back(find_anchor(pos));
        queries_seen++;
      end
    endfunction

    function void report_miss(string what, logic [ANCHOR_WIDTH-1:0] want,
                              logic [ANCHOR_WIDTH-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: anchor_index expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    function void check_result(logic [ANCHOR_WIDTH-1:0] got);
      logic [ANCHOR_WIDTH-1:0] want;
      results_seen++;
      if (anchors_due.size() == 0) begin
        report_miss("result with no query pending", '0, got);
        return;
      end
      want = anchors_due.pop_front();
      if (got !== want) report_miss("wrong anchor", want, got);
    endfunction

    function void close_out();
      while (anchors_due.size() != 0)
        report_miss("result never came", anchors_due.pop_front(), '0);
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic                         cmd;
  logic [ENTRY_INDEX_WIDTH-1:0] entry_index;
  logic [POS_PORT_WIDTH-1:0]    position;
  logic                         done;
  logic [ANCHOR_WIDTH-1:0]      anchor_index;
  logic                         cfg_wr_en;
  logic [COUNT_WIDTH-1:0]       cfg_wr_data;

  anchor_scoreboard sb = new();
  int  items_taken = 0;
  int  stall_cycles = 0;
  int  sizes_run = 0;
  bit  gaps_on = 1'b1;

  sorted_table_predecessor_search_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .entry_index  (entry_index),
    .position     (position),
    .done         (done),
    .anchor_index (anchor_index),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_request(cmd, entry_index, position);
        items_taken++;
      end
      if (cfg_wr_en) sb.set_count(cfg_wr_data);
      if (done) sb.check_result(anchor_index);
      if ((start && !busy) || done || cfg_wr_en) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("sorted_table_predecessor_search_unit_tb: done, errors");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic op, input logic [ENTRY_INDEX_WIDTH-1:0] slot,
                              input logic [POS_PORT_WIDTH-1:0] pos);
    int pause;
    if (gaps_on && $urandom_range(0, 99) < 36) begin
      pause = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    start       <= 1'b1;
    cmd         <= op;
    entry_index <= slot;
    position    <= pos;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start and hold until every query has answered and the block is idle.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (sb.anchors_due.size() != 0 || busy);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_entry_count(input logic [COUNT_WIDTH-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_sorted_table(input int count);
    logic [63:0] level;
    logic [63:0] stride;
    bit          top_out;
    stride  = ($urandom_range(0, 3) == 0) ? 64'd40 : 64'hFFFF_FFFF / count;
    level   = $urandom_range(0, 1000);
    top_out = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if (top_out && i == count - 1) level = 64'hFFFF_FFFF;
      send_request(CMD_WRITE, ENTRY_INDEX_WIDTH'(i), level[31:0]);
      if ($urandom_range(0, 4) != 0) level += $urandom_range(0, stride[31:0]);
      if (level > 64'hFFFF_FFFF) level = 64'hFFFF_FFFF;
    end
  endtask

  initial begin
    int                        phase_no;
    int                        size;
    int                        span;
    int                        pick;
    int                        slot_near;
    logic [POS_PORT_WIDTH-1:0] probe;

    rst         = 1'b1;
    start       = 1'b0;
    cmd         = CMD_WRITE;
    entry_index = '0;
    position    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(CMD_WRITE, 10'd0, 32'h0000_0100);
    send_request(CMD_QUERY, 10'd0, 32'h0000_0000);
    send_request(CMD_QUERY, 10'd1023, 32'h0000_00FF);
    send_request(CMD_QUERY, 10'd0, 32'h0000_0100);
    send_request(CMD_QUERY, 10'd0, 32'hFFFF_FFFF);
    write_entry_count(11'd0);
    send_request(CMD_WRITE, 10'd1, 32'h0000_0200);
    send_request(CMD_QUERY, 10'd0, 32'h0000_0300);
    write_entry_count(11'd2);
    send_request(CMD_QUERY, 10'd0, 32'h0000_01FF);
    send_request(CMD_QUERY, 10'd0, 32'h0000_0200);
    send_request(CMD_QUERY, 10'd0, 32'hFFFF_FFFF);
    send_request(CMD_WRITE, 10'd2, 32'hFFFF_FFFF);
    send_request(CMD_WRITE, 10'd1023, 32'hFFFF_FFFF);
    write_entry_count(11'd3);
    send_request(CMD_QUERY, 10'd0, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 10'd0, 32'hFFFF_FFFE);
    send_request(CMD_WRITE, 10'd1, 32'h0000_0000);
    send_request(CMD_QUERY, 10'd0, 32'h0000_0050);
    send_request(CMD_WRITE, 10'd0, 32'h0000_0000);
    send_request(CMD_QUERY, 10'd0, 32'h0000_0000);

    phase_no = 0;
    while (items_taken < ITEM_TARGET) begin
      phase_no++;
      if (phase_no == 3) begin
        size = TABLE_SIZE;
      end else if (phase_no > 3 && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: size = 0;
          1: size = TABLE_SIZE;
          2: size = TABLE_SIZE + 1;
          default: size = 2047;
        endcase
      end else begin
        size = $urandom_range(1, 48);
      end
      span = (size == 0) ? 1 : ((size > TABLE_SIZE) ? TABLE_SIZE : size);
      write_entry_count(COUNT_WIDTH'(size));
      gaps_on = (phase_no % 5 != 2);
      if (span <= 64 || phase_no == 3) load_sorted_table(span);
      repeat ($urandom_range(30, 60)) begin
        if ($urandom_range(0, 99) < 12) begin
          send_request(CMD_WRITE, ENTRY_INDEX_WIDTH'($urandom), $urandom);
        end else begin
          pick = $urandom_range(0, 99);
          slot_near = $urandom_range(0, span - 1);
          if (pick < 40) probe = $urandom;
          else if (pick < 45) probe = '0;
          else if (pick < 50) probe = '1;
          else probe = sb.starts[slot_near] + 32'($urandom_range(0, 2)) - 32'd1;
          send_request(CMD_QUERY, ENTRY_INDEX_WIDTH'($urandom), probe);
        end
      end
      sizes_run++;
    end

    gaps_on = 1'b1;
    settle();
    sb.close_out();
    $display("covered %0d table writes and %0d predecessor queries over %0d table sizes",
             sb.writes_seen, sb.queries_seen, sizes_run);
    $display("%0d anchors checked, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("sorted_table_predecessor_search_unit_tb: done, clean");
    end else begin
      $display("sorted_table_predecessor_search_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/stps_pkg.sv
src/stps_table.sv
src/stps_search.sv
src/sorted_table_predecessor_search_unit.sv
bench/sorted_table_predecessor_search_unit_tb.sv
